// File: rtl/sal_pkg.sv
// sal_pkg: shared constants, types and helper functions of the slot allocator.
// Used by the channel interfaces and by every rtl module of the block but sal_ram.
package sal_pkg;

  localparam int POOLS    = 4;
  localparam int SLOTS    = 256;
  localparam int POOL_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int CNT_W    = 9;
  localparam int WORD_W   = 16;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int ROWS     = SLOTS / WORD_W;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int WORDS    = POOLS * ROWS;
  localparam int ADDR_W   = POOL_W + ROW_W;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;
  localparam int REG_IX_W = $clog2(POOLS);

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(SLOTS);

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef logic [POOLS-1:0][CNT_W-1:0] cap_vec_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } ram_req_t;

  // lowest set bit of a row summary
  function automatic logic [ROW_W-1:0] first_row(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  // lowest set bit of a flag word
  function automatic logic [BIT_W-1:0] first_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/sal_if.sv
// sal_req_if / sal_rsp_if: valid/ready channels of the slot allocator.
// Depends on sal_pkg for field widths.
interface sal_req_if;
  import sal_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [POOL_W-1:0] pool;
  logic [SLOT_W-1:0] slot_in;
  modport source (output valid, kind, pool, slot_in, input ready);
  modport sink   (input valid, kind, pool, slot_in, output ready);
endinterface

interface sal_rsp_if;
  import sal_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_out;
  logic [1:0]        status;
  modport source (output valid, slot_out, status, input ready);
  modport sink   (input valid, slot_out, status, output ready);
endinterface

// File: rtl/slot_allocator_lowest_free.sv
// slot_allocator_lowest_free: lowest-free slot allocator over four pools.
// Items pass the lookup and then the decision stage into the result register.
// Throughput: one item per cycle unless rsp stalls; the flag RAM read for
// the next item overlaps this one's decision, with a bypass on a same-word write.
// Reset: capacities to 256, marks to zero, row summaries cleared (none flagged);
// no clearing pass, the item channel is ready right after reset.
module slot_allocator_lowest_free (
  input  logic                       clk,
  input  logic                       rst_n,
  sal_req_if.sink                    in_req,
  sal_rsp_if.source                  out_rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sal_pkg::APB_AW-1:0] paddr,
  input  logic [sal_pkg::APB_DW-1:0] pwdata,
  output logic [sal_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sal_pkg::*;

  cap_vec_t          cap;
  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rd_data;

  sal_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  sal_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  sal_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_req),
    .rsp         (out_rsp),
    .cap         (cap),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

endmodule

// File: rtl/sal_cfg.sv
// sal_cfg: APB register file holding the per-pool capacity registers.
// Depends on sal_pkg.
module sal_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sal_pkg::APB_AW-1:0] paddr,
  input  logic [sal_pkg::APB_DW-1:0] pwdata,
  output logic [sal_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output sal_pkg::cap_vec_t          cap
);
  import sal_pkg::*;

  cap_vec_t            cap_r;
  logic [REG_IX_W-1:0] reg_ix;

  assign reg_ix = paddr[APB_AW-1:2];
  assign pready = 1'b1;
  assign prdata = APB_DW'(cap_r[reg_ix]);
  assign cap    = cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOLS; i++) cap_r[i] <= CAP_RESET;
    end else if (psel && penable && pwrite) begin
      cap_r[reg_ix] <= pwdata[CNT_W-1:0];
    end
  end

endmodule

// File: rtl/sal_ram.sv
// sal_ram: simple dual-port RAM, one write and one registered read port.
// Holds the freed-slot flag words; no package dependency.
module sal_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

// File: rtl/sal_core.sv
// sal_core: two-stage request pipeline of the slot allocator: row lookup and
// flag word read, then grant/release decision, state update and result register.
// Depends on sal_pkg and the channel interfaces; drives the flag RAM.
module sal_core (
  input  logic                       clk,
  input  logic                       rst_n,
  sal_req_if.sink                    req,
  sal_rsp_if.source                  rsp,
  input  sal_pkg::cap_vec_t          cap,
  output sal_pkg::ram_req_t          ram_req,
  input  logic [sal_pkg::WORD_W-1:0] ram_rd_data
);
  import sal_pkg::*;

  // lookup stage
  logic              a_vld_r;
  logic              a_kind_r;
  logic [POOL_W-1:0] a_pool_r;
  logic [SLOT_W-1:0] a_slot_r;
  // decision stage
  logic              b_vld_r;
  logic              b_kind_r;
  logic [POOL_W-1:0] b_pool_r;
  logic [SLOT_W-1:0] b_slot_r;
  logic              b_byp_r;
  logic [WORD_W-1:0] b_byp_data_r;
  // result register
  logic              out_vld_r;
  logic [SLOT_W-1:0] out_slot_r;
  status_t           out_status_r;

  // per-pool row summary: bit set when the row's flag word holds a free slot.
  // a row whose summary bit is clear reads as all zero, so the RAM needs no clear
  logic [POOLS-1:0][ROWS-1:0]  nz_r, nz_nxt;
  logic [POOLS-1:0][CNT_W-1:0] hw_r, hw_nxt;

  logic b_fire, b_free, a_fire, in_fire;

  logic              pool_ok;
  logic [ROWS-1:0]   pool_nz;
  logic [ROW_W-1:0]  row_alloc, row;
  logic [WORD_W-1:0] word_raw, word;
  logic [BIT_W-1:0]  bit_alloc;
  logic [CNT_W-1:0]  hw, eff_cap;
  logic [WORD_W-1:0] wr_word;
  logic              wr_c;
  logic              hw_we_c;
  logic [CNT_W-1:0]  hw_new;
  logic [SLOT_W-1:0] res_slot;
  status_t           res_status;
  logic [ROW_W-1:0]  a_row;

  assign b_fire  = b_vld_r && (!out_vld_r || rsp.ready);
  assign b_free  = !b_vld_r || b_fire;
  assign a_fire  = a_vld_r && b_free;
  assign req.ready = !a_vld_r || a_fire;
  assign in_fire = req.valid && req.ready;

  assign rsp.valid    = out_vld_r;
  assign rsp.slot_out = out_slot_r;
  assign rsp.status   = out_status_r;

  // decision stage
  assign pool_ok   = ({1'b0, b_pool_r} < (POOL_W + 1)'(POOLS));
  assign pool_nz   = nz_r[b_pool_r];
  assign row_alloc = first_row(pool_nz);
  assign row       = (b_kind_r == KIND_RELEASE) ? b_slot_r[SLOT_W-1:BIT_W] : row_alloc;
  assign word_raw  = b_byp_r ? b_byp_data_r : ram_rd_data;
  assign word      = pool_nz[row] ? word_raw : '0;
  assign bit_alloc = first_bit(word);
  assign hw        = hw_r[b_pool_r];
  assign eff_cap   = (cap[b_pool_r] > CAP_MAX) ? CAP_MAX : cap[b_pool_r];

  always_comb begin
    res_slot   = '0;
    res_status = ST_OK;
    wr_word    = word;
    wr_c       = 1'b0;
    hw_we_c    = 1'b0;
    hw_new     = hw;
    if (!pool_ok) begin
      res_status = ST_INVALID;
      if (b_kind_r == KIND_RELEASE) res_slot = b_slot_r;
    end else if (b_kind_r == KIND_ALLOC) begin
      if (|pool_nz) begin
        res_slot = {row_alloc, bit_alloc};
        wr_word  = word & ~(WORD_W'(1) << bit_alloc);
        wr_c     = 1'b1;
      end else if (hw < eff_cap) begin
        res_slot = hw[SLOT_W-1:0];
        hw_new   = hw + CNT_W'(1);
        hw_we_c  = 1'b1;
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      res_slot = b_slot_r;
      if ((CNT_W'(b_slot_r) >= hw) || word[b_slot_r[BIT_W-1:0]]) begin
        res_status = ST_INVALID;
      end else if ((CNT_W'(b_slot_r) + CNT_W'(1)) == hw) begin
        // topmost in-use slot: pull the mark down instead of flagging it
        hw_new  = CNT_W'(b_slot_r);
        hw_we_c = 1'b1;
      end else begin
        wr_word = word | (WORD_W'(1) << b_slot_r[BIT_W-1:0]);
        wr_c    = 1'b1;
      end
    end
  end

  always_comb begin
    nz_nxt = nz_r;
    hw_nxt = hw_r;
    if (b_fire && wr_c) nz_nxt[b_pool_r][row] = |wr_word;
    if (b_fire && hw_we_c) hw_nxt[b_pool_r] = hw_new;
  end

  // lookup stage sees the summary as it will be after the decision stage commits
  assign a_row = (a_kind_r == KIND_RELEASE) ? a_slot_r[SLOT_W-1:BIT_W] :
                 first_row(nz_nxt[a_pool_r]);

  always_comb begin
    ram_req.rd_en   = a_fire;
    ram_req.rd_addr = {a_pool_r, a_row};
    ram_req.wr_en   = b_fire && wr_c;
    ram_req.wr_addr = {b_pool_r, row};
    ram_req.wr_data = wr_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      nz_r      <= '0;
      hw_r      <= '0;
    end else begin
      if (in_fire) a_vld_r <= 1'b1;
      else if (a_fire) a_vld_r <= 1'b0;
      if (a_fire) b_vld_r <= 1'b1;
      else if (b_fire) b_vld_r <= 1'b0;
      if (b_fire) out_vld_r <= 1'b1;
      else if (rsp.ready) out_vld_r <= 1'b0;
      nz_r <= nz_nxt;
      hw_r <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind_r <= req.kind;
      a_pool_r <= req.pool;
      a_slot_r <= req.slot_in;
    end
    if (a_fire) begin
      b_kind_r <= a_kind_r;
      b_pool_r <= a_pool_r;
      b_slot_r <= a_slot_r;
      // read during write of the same word returns old data: forward the new word
      b_byp_r      <= ram_req.wr_en && (ram_req.wr_addr == ram_req.rd_addr);
      b_byp_data_r <= wr_word;
    end
    if (b_fire) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
    end
  end

endmodule
